>>> rtl/nmea_sentence_validator_assert.svh
// Assertion macros shared by the sentence validator RTL.
`ifndef NMEA_SENTENCE_VALIDATOR_ASSERT_SVH
`define NMEA_SENTENCE_VALIDATOR_ASSERT_SVH

// Checks that a condition implies another in the same cycle.
`define NSV_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("nmea_sentence_validator: same-cycle check failed");

// Checks that a condition implies another in the next cycle.
`define NSV_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("nmea_sentence_validator: next-cycle check failed");

`endif

>>> rtl/nsv_pkg.sv
// Package with types and constants of the NMEA sentence validator.
package nsv_pkg;

  // Special characters of a sentence.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Number of tag bytes kept for comparison.
  localparam int TAG_BYTES = 5;

  // Known tags, first character in the low byte.
  localparam logic [39:0] TAG_CHARS_RMC = 40'h43_4D_52_50_47;
  localparam logic [39:0] TAG_CHARS_GGA = 40'h41_47_47_50_47;
  localparam logic [39:0] TAG_CHARS_GSA = 40'h41_53_47_50_47;
  localparam logic [39:0] TAG_CHARS_GSV = 40'h56_53_47_50_47;

  // Reset values of the minimum field counts.
  localparam logic [4:0] MIN_RMC_RST = 5'd12;
  localparam logic [4:0] MIN_GGA_RST = 5'd14;
  localparam logic [4:0] MIN_GSA_RST = 5'd17;
  localparam logic [4:0] MIN_GSV_RST = 5'd19;

  // Depth of the queue between front and back.
  localparam int FIFO_DEPTH = 2;

  typedef enum logic [2:0] {
    V_KNOWN_OK   = 3'd0,
    V_UNKNOWN_OK = 3'd1,
    V_NO_DOLLAR  = 3'd2,
    V_NO_STAR    = 3'd3,
    V_MISMATCH   = 3'd4,
    V_NO_COMMA   = 3'd5,
    V_FEW_FIELDS = 3'd6
  } verdict_e;

  typedef enum logic [2:0] {
    TAG_UNKNOWN = 3'd0,
    TAG_RMC     = 3'd1,
    TAG_GGA     = 3'd2,
    TAG_GSA     = 3'd3,
    TAG_GSV     = 3'd4
  } tag_e;

  typedef enum logic [1:0] {
    CFG_MIN_RMC = 2'd0,
    CFG_MIN_GGA = 2'd1,
    CFG_MIN_GSA = 2'd2,
    CFG_MIN_GSV = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    PH_EXPECT_DOLLAR = 1'b0,
    PH_BODY          = 1'b1
  } phase_e;

  // Input transaction payload.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_sentence;
  } nsv_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [2:0] verdict;
    logic [2:0] tag_code;
    logic [4:0] num_fields;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } nsv_out_t;

  // Classified byte, as queued from front to back.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       eos;
    logic       is_nul;
    logic       is_dollar;
    logic       is_star;
    logic       is_comma;
    logic       is_hex;
    logic [3:0] hex_val;
  } nsv_class_t;

  // Minimum field counts of the known tags.
  typedef struct packed {
    logic [4:0] rmc;
    logic [4:0] gga;
    logic [4:0] gsa;
    logic [4:0] gsv;
  } nsv_limits_t;

endpackage

>>> rtl/nsv_front.sv
// Front end: accepts sentence bytes and classifies them for the queue.
module nsv_front
  import nsv_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  nsv_in_t    in_data_i,
  input  logic       fifo_full_i,
  output logic       push_o,
  output nsv_class_t push_data_o
);

  logic [7:0] c;

  assign c          = in_data_i.char_byte;
  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // Decode the byte into the classes the back end needs.
  always_comb begin
    push_data_o           = '0;
    push_data_o.char_byte = c;
    push_data_o.eos       = in_data_i.end_of_sentence;
    push_data_o.is_nul    = (c == CH_NUL);
    push_data_o.is_dollar = (c == CH_DOLLAR);
    push_data_o.is_star   = (c == CH_STAR);
    push_data_o.is_comma  = (c == CH_COMMA);
    if (c >= 8'h30 && c <= 8'h39) begin
      push_data_o.is_hex  = 1'b1;
      push_data_o.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // Letters a-f and A-F share their low three bits.
      push_data_o.is_hex  = 1'b1;
      push_data_o.hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
    end
  end

endmodule

>>> rtl/nsv_fifo.sv
// Short queue of classified bytes between front and back.
module nsv_fifo
  import nsv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  nsv_class_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output nsv_class_t head_data_o
);

  localparam int PtrW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CntW = $clog2(FIFO_DEPTH + 1);

  nsv_class_t          mem_q [FIFO_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o       = (count_q == CntW'(FIFO_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/nsv_back.sv
// Back end: sentence state update, verdict and result register.
module nsv_back
  import nsv_pkg::*;
#(
  parameter int MAX_FIELDS  = 31,
  parameter int MAX_TAG_LEN = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  nsv_class_t  head_data_i,
  output logic        pop_o,
  input  nsv_limits_t limits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output nsv_out_t    out_data_o
);

  localparam int TallyW = $clog2(MAX_FIELDS + 1);
  localparam int TagLenW = $clog2(MAX_TAG_LEN + 1);

  typedef struct packed {
    phase_e             phase;
    logic [7:0]         run_xor;
    logic [39:0]        tag_chars;
    logic [TagLenW-1:0] tag_len;
    logic               comma_seen;
    logic [TallyW-1:0]  tally;
    logic               data_nonempty;
    logic [7:0]         hex_value;
    logic               hex_ovf;
    logic               hex_stop;
    logic               star_seen;
    logic               dollar_ok;
    logic               nul_seen;
  } sent_t;

  sent_t         sent_q, sent_d, upd;
  logic          out_valid_q, out_valid_d;
  nsv_out_t      out_data_q, result;
  nsv_class_t    b;
  logic          finish;
  logic [TallyW:0] count;
  tag_e          tag;
  logic [4:0]    min_req;

  assign b           = head_data_i;
  assign pop_o       = head_valid_i && (!b.eos || !out_valid_q || out_ready_i);
  assign finish      = pop_o && b.eos;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Per-byte state update.
  always_comb begin
    upd = sent_q;
    if (!sent_q.nul_seen) begin
      if (b.is_nul) begin
        upd.nul_seen = 1'b1;
      end else if (sent_q.phase == PH_EXPECT_DOLLAR) begin
        upd.phase     = PH_BODY;
        upd.dollar_ok = b.is_dollar;
      end else if (sent_q.star_seen) begin
        // Received checksum digits; the first non-digit ends the run.
        if (!sent_q.hex_stop) begin
          if (!b.is_hex) begin
            upd.hex_stop = 1'b1;
          end else begin
            if (sent_q.hex_value[7:4] != 4'd0) begin
              upd.hex_ovf = 1'b1;
            end
            upd.hex_value = {sent_q.hex_value[3:0], b.hex_val};
          end
        end
      end else if (b.is_star) begin
        upd.star_seen = 1'b1;
      end else begin
        upd.run_xor = sent_q.run_xor ^ b.char_byte;
        if (!sent_q.comma_seen) begin
          if (b.is_comma) begin
            upd.comma_seen = 1'b1;
          end else if (sent_q.tag_len < TagLenW'(MAX_TAG_LEN)) begin
            for (int k = 0; k < TAG_BYTES; k++) begin
              if (sent_q.tag_len == TagLenW'(k)) begin
                upd.tag_chars[8*k +: 8] = b.char_byte;
              end
            end
            upd.tag_len = sent_q.tag_len + 1'b1;
          end
        end else begin
          upd.data_nonempty = 1'b1;
          if (b.is_comma && sent_q.tally < TallyW'(MAX_FIELDS)) begin
            upd.tally = sent_q.tally + 1'b1;
          end
        end
      end
    end
  end

  // Next state: the last byte of a sentence clears everything.
  always_comb begin
    sent_d = sent_q;
    if (pop_o) begin
      sent_d = b.eos ? sent_t'('0) : upd;
    end
  end

  // Tag lookup and field count of the updated state.
  always_comb begin
    tag   = TAG_UNKNOWN;
    count = '0;
    if (upd.comma_seen) begin
      if (upd.data_nonempty) begin
        count = {1'b0, upd.tally} + 1'b1;
        if (count > (TallyW + 1)'(MAX_FIELDS)) begin
          count = (TallyW + 1)'(MAX_FIELDS);
        end
      end
      if (upd.tag_len == TagLenW'(TAG_BYTES)) begin
        if (upd.tag_chars == TAG_CHARS_RMC) begin
          tag = TAG_RMC;
        end else if (upd.tag_chars == TAG_CHARS_GGA) begin
          tag = TAG_GGA;
        end else if (upd.tag_chars == TAG_CHARS_GSA) begin
          tag = TAG_GSA;
        end else if (upd.tag_chars == TAG_CHARS_GSV) begin
          tag = TAG_GSV;
        end
      end
    end
  end

  // Verdict: the first failing check wins.
  always_comb begin
    case (tag)
      TAG_RMC: min_req = limits_i.rmc;
      TAG_GGA: min_req = limits_i.gga;
      TAG_GSA: min_req = limits_i.gsa;
      TAG_GSV: min_req = limits_i.gsv;
      default: min_req = 5'd0;
    endcase
    result              = '0;
    result.tag_code     = tag;
    result.num_fields   = (count > (TallyW + 1)'(31)) ? 5'd31 : count[4:0];
    result.computed_sum = upd.run_xor;
    result.received_sum = upd.star_seen ? upd.hex_value : 8'd0;
    if (!upd.dollar_ok) begin
      result.verdict = V_NO_DOLLAR;
    end else if (!upd.star_seen) begin
      result.verdict = V_NO_STAR;
    end else if (upd.hex_ovf || upd.hex_value != upd.run_xor) begin
      result.verdict = V_MISMATCH;
    end else if (!upd.comma_seen) begin
      result.verdict = V_NO_COMMA;
    end else if (tag == TAG_UNKNOWN) begin
      result.verdict = V_UNKNOWN_OK;
    end else if (count < (TallyW + 1)'(min_req)) begin
      result.verdict = V_FEW_FIELDS;
    end else begin
      result.verdict = V_KNOWN_OK;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sent_q      <= sent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_data_q <= result;
    end
  end

endmodule

>>> rtl/nmea_sentence_validator.sv
// Top level of the NMEA sentence validator: configuration, queue and units.
// The validator takes one sentence byte per transaction and gives one result
// transaction on the byte flagged as end of sentence. Bytes are accepted at
// one per cycle while the queue has room: the front end classifies each byte
// into a two-entry queue, and the back end folds one queued byte per cycle
// into the sentence state; an end-of-sentence byte passes through the queue
// and then the result register. A waiting result stalls the back end only
// once the next end-of-sentence byte reaches the head of the queue; the queue
// then takes one more byte before the input stalls. The minimum field counts
// are to be written by the user through the configuration port while no
// sentence is in flight; the block itself does not enforce this.
`include "nmea_sentence_validator_assert.svh"

module nmea_sentence_validator
  import nsv_pkg::*;
#(
  parameter int MAX_FIELDS  = 31,
  parameter int MAX_TAG_LEN = 12
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  nsv_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output nsv_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [4:0] cfg_wdata_i
);

  nsv_limits_t limits_q, limits_d;
  logic        push, fifo_full, pop, head_valid;
  nsv_class_t  push_data, head_data;

  // Configuration registers.
  always_comb begin
    limits_d = limits_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_RMC: limits_d.rmc = cfg_wdata_i;
        CFG_MIN_GGA: limits_d.gga = cfg_wdata_i;
        CFG_MIN_GSA: limits_d.gsa = cfg_wdata_i;
        CFG_MIN_GSV: limits_d.gsv = cfg_wdata_i;
        default:     limits_d = limits_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q <= '{rmc: MIN_RMC_RST, gga: MIN_GGA_RST, gsa: MIN_GSA_RST, gsv: MIN_GSV_RST};
    end else begin
      limits_q <= limits_d;
    end
  end

  nsv_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  nsv_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (fifo_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  nsv_back #(
    .MAX_FIELDS  (MAX_FIELDS),
    .MAX_TAG_LEN (MAX_TAG_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .limits_i     (limits_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // A finished sentence always shows up as a result in the next cycle.
  `NSV_ASSERT_NEXT(a_eos_gives_result, clk_i, rst_ni, pop && head_data.eos, out_valid_o)
  // A known-tag pass always carries a known tag code.
  `NSV_ASSERT_IMPLIES(a_known_has_tag, clk_i, rst_ni,
    out_valid_o && out_data_o.verdict == V_KNOWN_OK, out_data_o.tag_code != TAG_UNKNOWN)
  // An unknown-tag pass never carries a tag code.
  `NSV_ASSERT_IMPLIES(a_unknown_no_tag, clk_i, rst_ni,
    out_valid_o && out_data_o.verdict == V_UNKNOWN_OK, out_data_o.tag_code == TAG_UNKNOWN)
  // Without a comma there is neither tag nor field.
  `NSV_ASSERT_IMPLIES(a_no_comma_empty, clk_i, rst_ni,
    out_valid_o && out_data_o.verdict == V_NO_COMMA,
    out_data_o.tag_code == TAG_UNKNOWN && out_data_o.num_fields == 5'd0)

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the NMEA sentence validator.
module tb;
  import nsv_pkg::*;

  localparam int FIELD_CAP      = 31;
  localparam int TAG_KEEP       = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_OFF       = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // Characters used to read hex digits and to build sentences.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Kinds of damage done to an otherwise well-formed sentence.
  typedef enum int {
    FLAW_NONE,
    FLAW_FIRST_BYTE,
    FLAW_NO_STAR,
    FLAW_NUL_INSIDE,
    FLAW_NO_COMMA,
    FLAW_TRAILER,
    FLAW_BAD_SUM
  } flaw_e;

  // One directed sentence; a tilde in the text stands for a zero byte.
  typedef struct {
    string    text;
    bit       typed;
    nsv_out_t want;
  } script_row_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  nsv_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  nsv_out_t out_data_o;
  logic     cfg_we_i    = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [4:0] cfg_wdata_i = '0;

  // Shared test control.
  nsv_out_t awaited_verdicts [$];
  int       fault_count  = 0;
  int       idle_cycles  = 0;
  int       bytes_sent   = 0;
  bit       steady       = 1'b0;
  bit       hold_off_req = 1'b0;

  // Mirror of the sentence state and of the minimum field counts.
  logic [4:0]  field_floor [4];
  phase_e      snt_phase;
  logic [7:0]  xor_acc;
  logic [39:0] tag_acc;
  int          tag_len_acc;
  bit          comma_hit;
  int          comma_cnt;
  bit          data_hit;
  logic [7:0]  hex_acc;
  bit          hex_ovf;
  bit          hex_done;
  bit          star_hit;
  bit          dollar_hit;
  bit          nul_hit;

  nmea_sentence_validator #(
    .MAX_FIELDS (FIELD_CAP),
    .MAX_TAG_LEN(TAG_KEEP)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_sentence_state();
    snt_phase   = PH_EXPECT_DOLLAR;
    xor_acc     = '0;
    tag_acc     = '0;
    tag_len_acc = 0;
    comma_hit   = 1'b0;
    comma_cnt   = 0;
    data_hit    = 1'b0;
    hex_acc     = '0;
    hex_ovf     = 1'b0;
    hex_done    = 1'b0;
    star_hit    = 1'b0;
    dollar_hit  = 1'b0;
    nul_hit     = 1'b0;
  endfunction

  // Folds one byte into the sentence state; on the last byte it returns the verdict.
  function automatic nsv_out_t advance_sentence(input logic [7:0] c, input logic last);
    nsv_out_t   res;
    logic [3:0] nib;
    bit         is_hex;
    int         fields;
    tag_e       tag;
    res    = '0;
    fields = 0;
    tag    = TAG_UNKNOWN;
    nib    = '0;
    is_hex = 1'b1;
    if (!nul_hit) begin
      if (c == CH_NUL) begin
        nul_hit = 1'b1;
      end else if (snt_phase == PH_EXPECT_DOLLAR) begin
        snt_phase  = PH_BODY;
        dollar_hit = (c == CH_DOLLAR);
      end else if (star_hit) begin
        // Hex digits after the star, up to the first other byte.
        if (!hex_done) begin
          if (c >= CH_ZERO && c <= CH_NINE) nib = 4'(c - CH_ZERO);
          else if (c >= CH_LO_A && c <= CH_LO_F) nib = 4'(c - CH_LO_A + 8'd10);
          else if (c >= CH_UP_A && c <= CH_UP_F) nib = 4'(c - CH_UP_A + 8'd10);
          else is_hex = 1'b0;
          if (!is_hex) begin
            hex_done = 1'b1;
          end else begin
            if (hex_acc[7:4] != 4'd0) hex_ovf = 1'b1;
            hex_acc = {hex_acc[3:0], nib};
          end
        end
      end else if (c == CH_STAR) begin
        star_hit = 1'b1;
      end else begin
        xor_acc ^= c;
        if (!comma_hit) begin
          if (c == CH_COMMA) begin
            comma_hit = 1'b1;
          end else if (tag_len_acc < TAG_KEEP) begin
            if (tag_len_acc < TAG_BYTES) tag_acc[8*tag_len_acc +: 8] = c;
            tag_len_acc++;
          end
        end else begin
          data_hit = 1'b1;
          if (c == CH_COMMA && comma_cnt < FIELD_CAP) comma_cnt++;
        end
      end
    end

    if (last) begin
      if (comma_hit) begin
        if (data_hit) fields = (comma_cnt + 1 > FIELD_CAP) ? FIELD_CAP : comma_cnt + 1;
        if (tag_len_acc == TAG_BYTES) begin
          case (tag_acc)
            TAG_CHARS_RMC: tag = TAG_RMC;
            TAG_CHARS_GGA: tag = TAG_GGA;
            TAG_CHARS_GSA: tag = TAG_GSA;
            TAG_CHARS_GSV: tag = TAG_GSV;
            default:       tag = TAG_UNKNOWN;
          endcase
        end
      end
      // The first failing check decides the verdict.
      if (!dollar_hit) res.verdict = V_NO_DOLLAR;
      else if (!star_hit) res.verdict = V_NO_STAR;
      else if (hex_ovf || hex_acc != xor_acc) res.verdict = V_MISMATCH;
      else if (!comma_hit) res.verdict = V_NO_COMMA;
      else if (tag == TAG_UNKNOWN) res.verdict = V_UNKNOWN_OK;
      else if (fields < int'(field_floor[int'(tag) - 1])) res.verdict = V_FEW_FIELDS;
      else res.verdict = V_KNOWN_OK;
      res.tag_code     = tag;
      res.num_fields   = 5'((fields > 31) ? 31 : fields);
      res.computed_sum = xor_acc;
      res.received_sum = star_hit ? hex_acc : 8'h00;
      clear_sentence_state();
    end
    return res;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return CH_ZERO + 8'(v);
    return (lower ? CH_LO_A : CH_UP_A) + 8'(v) - 8'd10;
  endfunction

  // Printable data byte that is neither a separator nor a star.
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_SPACE, CH_TILDE));
    while (c == CH_COMMA || c == CH_STAR);
    return c;
  endfunction

  task automatic note_fault(input string what, input nsv_out_t want, input nsv_out_t got);
    if (fault_count < REPORT_LIMIT) begin
      $display("%s: expected verdict=%0d tag=%0d fields=%0d sum=%02h rx=%02h",
               what, want.verdict, want.tag_code, want.num_fields,
               want.computed_sum, want.received_sum);
      $display("  got verdict=%0d tag=%0d fields=%0d sum=%02h rx=%02h",
               got.verdict, got.tag_code, got.num_fields,
               got.computed_sum, got.received_sum);
    end
    fault_count++;
  endtask

  // Offers one byte transaction and records the verdict it is due to give.
  task automatic send_byte(input logic [7:0] c, input logic last,
                           input bit typed, input nsv_out_t typed_want);
    nsv_out_t predicted;
    int       gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{char_byte: c, end_of_sentence: last};
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
    predicted = advance_sentence(c, last);
    if (last) awaited_verdicts.push_back(typed ? typed_want : predicted);
  endtask

  // Builds one sentence, mostly well-formed, and sends it.
  task automatic random_sentence();
    logic [7:0]  text [$];
    logic [39:0] tag;
    logic [7:0]  sum;
    flaw_e       flaw;
    int          style;
    int          fields;
    int          extra;
    int          star_at;
    bit          lower;
    style = $urandom_range(0, 9);
    flaw  = (style >= 7) ? flaw_e'($urandom_range(FLAW_FIRST_BYTE, FLAW_BAD_SUM)) : FLAW_NONE;
    if (style == 9) begin
      // Plain noise, any byte values.
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      text.push_back(CH_DOLLAR);
      case ($urandom_range(0, 5))
        0:       tag = TAG_CHARS_RMC;
        1:       tag = TAG_CHARS_GGA;
        2:       tag = TAG_CHARS_GSA;
        3:       tag = TAG_CHARS_GSV;
        default: tag = '0;
      endcase
      if (tag != '0) begin
        for (int k = 0; k < TAG_BYTES; k++) text.push_back(tag[8*k +: 8]);
        extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
      end else begin
        extra = $urandom_range(0, 15);
      end
      repeat (extra) text.push_back(8'($urandom_range(CH_UP_A, CH_UP_Z)));
      if (flaw != FLAW_NO_COMMA) begin
        text.push_back(CH_COMMA);
        // Mostly a few fields, now and then enough to saturate the count.
        fields = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 34) : $urandom_range(0, 6);
        for (int f = 0; f < fields; f++) begin
          if (f > 0) text.push_back(CH_COMMA);
          repeat ($urandom_range(0, 2)) text.push_back(field_char());
        end
      end
      sum = '0;
      for (int k = 1; k < text.size(); k++) sum ^= text[k];
      if (flaw == FLAW_BAD_SUM) sum ^= 8'h01 << $urandom_range(0, 7);
      star_at = text.size();
      text.push_back(CH_STAR);
      lower = 1'($urandom_range(0, 1));
      if (sum[7:4] != 4'd0 || $urandom_range(0, 1) == 1) text.push_back(hex_char(sum[7:4], lower));
      text.push_back(hex_char(sum[3:0], lower));
      case (flaw)
        FLAW_FIRST_BYTE: text[0] = 8'($urandom_range(0, 255));
        FLAW_NO_STAR:    text = text[0:star_at-1];
        FLAW_NUL_INSIDE: text.insert($urandom_range(0, text.size() - 1), CH_NUL);
        FLAW_TRAILER: begin
          // Either a stop byte before a stray digit or one more digit, which can overflow.
          if ($urandom_range(0, 1) == 1) text.push_back(CH_UP_G);
          text.push_back(hex_char(4'($urandom_range(0, 15)), lower));
        end
        default: ;
      endcase
    end
    foreach (text[k]) send_byte(text[k], k == text.size() - 1, 1'b0, '0);
  endtask

  // Lets all outstanding verdicts arrive, then lets the design settle.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (awaited_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_floors(input logic [4:0] floors [4]);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_idx_e'(i);
      cfg_wdata_i <= floors[i];
      @(posedge clk_i);
      field_floor[i] = floors[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  // Main stimulus: directed sentences, then random ones under several settings.
  initial begin : stimulus
    script_row_t script [8];
    logic [4:0]  floors [4];
    logic [7:0]  ch;
    int          phase_start;
    int          phase_sentences;
    script[0] = '{"~", 1'b1, '{V_NO_DOLLAR, TAG_UNKNOWN, 5'd0, 8'h00, 8'h00}};
    script[1] = '{"$", 1'b1, '{V_NO_STAR, TAG_UNKNOWN, 5'd0, 8'h00, 8'h00}};
    script[2] = '{"$*g1", 1'b1, '{V_NO_COMMA, TAG_UNKNOWN, 5'd0, 8'h00, 8'h00}};
    script[3] = '{"$,*2C", 1'b1, '{V_UNKNOWN_OK, TAG_UNKNOWN, 5'd0, 8'h2C, 8'h2C}};
    script[4] = '{"$*1a0", 1'b1, '{V_MISMATCH, TAG_UNKNOWN, 5'd0, 8'h00, 8'hA0}};
    script[5] = '{"$,~*", 1'b1, '{V_NO_STAR, TAG_UNKNOWN, 5'd0, 8'h2C, 8'h00}};
    script[6] = '{"$GPGSV,,*55", 1'b1, '{V_FEW_FIELDS, TAG_GSV, 5'd2, 8'h55, 8'h55}};
    script[7] = '{"$GpX,a,*", 1'b0, '0};

    field_floor = '{MIN_RMC_RST, MIN_GGA_RST, MIN_GSA_RST, MIN_GSV_RST};
    clear_sentence_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sentences under the reset settings.
    foreach (script[r]) begin
      steady = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < script[r].text.len(); i++) begin
        ch = script[r].text[i];
        send_byte((ch == CH_TILDE) ? CH_NUL : ch, i == script[r].text.len() - 1,
                  script[r].typed, script[r].want);
      end
    end

    // Random sentences: reset values, all zero, all maximum, then small random counts.
    for (int setting = 0; setting < 4; setting++) begin
      if (setting > 0) begin
        settle();
        for (int i = 0; i < 4; i++) begin
          case (setting)
            1:       floors[i] = 5'd0;
            2:       floors[i] = 5'd31;
            default: floors[i] = 5'($urandom_range(0, 8));
          endcase
        end
        load_floors(floors);
      end
      phase_start     = bytes_sent;
      phase_sentences = 0;
      while (bytes_sent - phase_start < 170 || phase_sentences < 8) begin
        steady = ($urandom_range(0, 3) == 0);
        if (setting == 1 && phase_sentences == 3) hold_off_req = 1'b1;
        random_sentence();
        phase_sentences++;
      end
    end

    settle();
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random stalls, and one long hold-off to back up the input.
  initial begin : result_sink
    int stall;
    wait (rst_ni);
    forever begin
      if (hold_off_req) begin
        stall        = HOLD_OFF;
        hold_off_req = 1'b0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Each result transaction is compared with the oldest awaited verdict.
  always @(posedge clk_i) begin : result_check
    nsv_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_verdicts.size() == 0) begin
        note_fault("Result with nothing awaited", '0, out_data_o);
      end else begin
        want = awaited_verdicts.pop_front();
        if (out_data_o.verdict !== want.verdict || out_data_o.tag_code !== want.tag_code ||
            out_data_o.num_fields !== want.num_fields ||
            out_data_o.computed_sum !== want.computed_sum ||
            out_data_o.received_sum !== want.received_sum)
          note_fault("Verdict mismatch", want, out_data_o);
      end
    end
  end

  // Ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

endmodule
